// File: rtl/cubic_curve_solve_and_evaluate_core_macros.svh
// Assertion macros shared by the cubic curve core RTL.
// Expects clk and rst_n in the scope of use.
`ifndef CUBIC_CURVE_SOLVE_AND_EVALUATE_CORE_MACROS_SVH
`define CUBIC_CURVE_SOLVE_AND_EVALUATE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ccse_pkg.sv
// Shared types and constants for the cubic curve solve and evaluate core.
// No dependencies.
`timescale 1ns / 1ps

package ccse_pkg;

  localparam int COEF_W     = 64;
  localparam int COEF_FRAC  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ORDER_W    = 3;
  localparam int VALUE_W    = 32;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_POSITION     = 3'd0,
    REG_START_VELOCITY     = 3'd1,
    REG_START_ACCELERATION = 3'd2,
    REG_END_POSITION       = 3'd3,
    REG_HORIZON            = 3'd4,
    REG_BOUNDARY_MODE      = 3'd5
  } cfg_reg_t;

  localparam logic [ORDER_W-1:0] ORD_VALUE     = 3'd0;
  localparam logic [ORDER_W-1:0] ORD_SLOPE     = 3'd1;
  localparam logic [ORDER_W-1:0] ORD_CURVATURE = 3'd2;
  localparam logic [ORDER_W-1:0] ORD_JERK      = 3'd3;

  // Solver status and coefficients handed to the evaluator
  typedef struct packed {
    logic  busy;
    logic  solved_valid;
    coef_t c0;
    coef_t c1;
    coef_t c2;
    coef_t c3;
  } solve_t;

endpackage

// File: rtl/cubic_curve_solve_and_evaluate_core.sv
// Takes one item per cycle unless the output stalls or a coefficient solve is running.
// The pipeline is a capture stage, three Horner steps (multiply, sum, saturate) and a
// rounding output stage. A configuration write to a defined register re-solves the
// coefficients (one division in boundary mode 0, two in mode 1) and holds off input.
// Synchronous active-low reset clears config registers, coefficients and valid bits.
`timescale 1ns / 1ps
`include "cubic_curve_solve_and_evaluate_core_macros.svh"

module cubic_curve_solve_and_evaluate_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [31:0] position
  input  logic [ccse_pkg::ORDER_W-1:0]    in_tuser,   // [2:0] derivative_order
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ccse_pkg::VALUE_W-1:0]    out_tdata,  // [31:0] curve_value
  output logic                            out_tuser,  // [0] curve_valid
  input  logic                            cfg_wr_en,
  input  logic [ccse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccse_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import ccse_pkg::*;

  localparam int NSTEP     = 3;
  localparam int NST       = 2 + 3*NSTEP;
  localparam int SHIFT_OUT = COEF_FRAC - FRACTION_BITS;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic signed [31:0] pos;
    coef_t              acc;
  } item_t;

  function automatic coef_t sat_67(input logic signed [66:0] x);
    if (x[66:63] == {4{x[63]}}) sat_67 = x[63:0];
    else sat_67 = x[66] ? coef_t'(64'h8000_0000_0000_0000) : coef_t'(64'h7FFF_FFFF_FFFF_FFFF);
  endfunction

  function automatic coef_t sat_96(input logic signed [95:0] x);
    if (x[95:63] == {33{x[63]}}) sat_96 = x[63:0];
    else sat_96 = x[95] ? coef_t'(64'h8000_0000_0000_0000) : coef_t'(64'h7FFF_FFFF_FFFF_FFFF);
  endfunction

  solve_t solver;

  ccse_solver #(.FRACTION_BITS(FRACTION_BITS)) u_solver (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .solve_o    (solver)
  );

  logic [NST-1:0] v_r, en;
  logic           in_accept;

  // Each stage advances when empty or when the stage after it advances
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int k = NST-2; k >= 0; k--)
      en[k] = !v_r[k] || en[k+1];
  end

  assign in_tready = en[0] && !solver.busy;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_accept;
      for (int k = 1; k < NST; k++)
        if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  // Lead coefficient and scaled addend
  logic signed [66:0] c3_w, c2_w;
  coef_t              c3x3, c3x6, c2x2, lead;

  assign c3_w = {{3{solver.c3[63]}}, solver.c3};
  assign c2_w = {{3{solver.c2[63]}}, solver.c2};
  assign c3x3 = sat_67((c3_w <<< 1) + c3_w);
  assign c3x6 = sat_67((c3_w <<< 2) + (c3_w <<< 1));
  assign c2x2 = sat_67(c2_w <<< 1);

  always_comb begin
    case (in_tuser) inside
      ORD_VALUE:               lead = solver.c3;
      ORD_SLOPE:               lead = c3x3;
      ORD_CURVATURE, ORD_JERK: lead = c3x6;
      default:                 lead = '0;
    endcase
  end

  item_t item0_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      item0_r.order <= in_tuser;
      item0_r.pos   <= in_tdata;
      item0_r.acc   <= lead;
    end
  end

  item_t              step_in   [NSTEP];
  item_t              item_m_r  [NSTEP];
  item_t              item_s_r  [NSTEP];
  item_t              item_a_r  [NSTEP];
  logic signed [63:0] ph_r      [NSTEP];
  logic signed [64:0] pl_r      [NSTEP];
  logic signed [95:0] w_r       [NSTEP];
  coef_t              addend    [NSTEP];

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    logic signed [95:0] w_sum, w_sh;
    logic signed [64:0] a_sum;
    coef_t              r64;
    logic               active;

    if (j == 0) begin : g_first
      assign step_in[j] = item0_r;
      assign addend[j]  = (item_s_r[j].order == ORD_VALUE) ? solver.c2 : c2x2;
    end else begin : g_next
      assign step_in[j] = item_a_r[j-1];
      assign addend[j]  = (j == 1) ? solver.c1 : solver.c0;
    end

    // Split the 64-bit accumulator into two 32-bit halves and multiply each by the position
    always_ff @(posedge clk) begin
      if (en[1 + 3*j]) begin
        item_m_r[j] <= step_in[j];
        ph_r[j]     <= $signed(step_in[j].acc[63:32]) * step_in[j].pos;
        pl_r[j]     <= $signed({1'b0, step_in[j].acc[31:0]}) * step_in[j].pos;
      end
    end

    assign w_sum = $signed({ph_r[j], 32'b0}) + $signed({{31{pl_r[j][64]}}, pl_r[j]})
                   + $signed(96'd1 << (FRACTION_BITS - 1));

    always_ff @(posedge clk) begin
      if (en[2 + 3*j]) begin
        item_s_r[j] <= item_m_r[j];
        w_r[j]      <= w_sum;
      end
    end

    assign w_sh   = w_r[j] >>> FRACTION_BITS;
    assign r64    = sat_96(w_sh);
    assign a_sum  = {r64[63], r64} + {addend[j][63], addend[j]};
    assign active = (item_s_r[j].order <= ORDER_W'(NSTEP - 1 - j));

    always_ff @(posedge clk) begin
      if (en[3 + 3*j]) begin
        item_a_r[j].order <= item_s_r[j].order;
        item_a_r[j].pos   <= item_s_r[j].pos;
        if (active)
          item_a_r[j].acc <= (a_sum[64] == a_sum[63]) ? a_sum[63:0] :
                             (a_sum[64] ? coef_t'(64'h8000_0000_0000_0000)
                                        : coef_t'(64'h7FFF_FFFF_FFFF_FFFF));
        else
          item_a_r[j].acc <= item_s_r[j].acc;
      end
    end
  end

  // Round to the output fraction and saturate to 32 bits
  logic signed [64:0]         fin_sum, fin_sh;
  logic signed [VALUE_W-1:0]  out_value_r;
  logic [ORDER_W-1:0]         out_order_r;

  assign fin_sum = {item_a_r[NSTEP-1].acc[63], item_a_r[NSTEP-1].acc}
                   + $signed(65'd1 << (SHIFT_OUT - 1));
  assign fin_sh  = fin_sum >>> SHIFT_OUT;

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_order_r <= item_a_r[NSTEP-1].order;
      if (fin_sh[64:31] == {34{fin_sh[31]}})
        out_value_r <= fin_sh[31:0];
      else
        out_value_r <= fin_sh[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = out_value_r;
  assign out_tuser  = solver.solved_valid;

  `CCSE_ASSERT_SAME(a_busy_blocks_input, solver.busy, !in_tready,
                    "input taken during solve")
  `CCSE_ASSERT_NEXT(a_write_starts_solve, cfg_wr_en && (cfg_index <= REG_BOUNDARY_MODE),
                    solver.busy, "config write did not start solve")
  `CCSE_ASSERT_SAME(a_high_order_zero, out_tvalid && (out_order_r > ORD_JERK),
                    out_tdata == '0, "order above three gave nonzero value")
  `CCSE_ASSERT_SAME(a_invalid_zero_coefs, !solver.solved_valid,
                    (solver.c3 == '0) && (solver.c2 == '0), "invalid curve kept coefficients")

endmodule

// File: rtl/ccse_solver.sv
// Configuration registers and coefficient solver: shared multiplier sequence
// followed by a bit-serial 128-bit restoring divider. Depends on ccse_pkg.
`timescale 1ns / 1ps

module ccse_solver #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ccse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccse_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  output ccse_pkg::solve_t                solve_o
);
  import ccse_pkg::*;

  localparam int UP    = COEF_FRAC - FRACTION_BITS;
  localparam int QW    = 128;
  localparam int CNT_W = $clog2(QW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5,
    ST_SUM, ST_NUM, ST_DNEG, ST_DADD, ST_DIV, ST_DEND
  } state_t;

  function automatic logic signed [QW-1:0] ext_wide(input logic signed [64:0] x);
    ext_wide = {{(QW-65){x[64]}}, x};
  endfunction

  logic signed [31:0] start_pos_r, start_vel_r, start_acc_r, end_pos_r;
  logic        [30:0] horizon_r;
  logic               mode_r;
  logic               start;

  state_t             state_r;
  logic               valid_r;
  coef_t              c0_r, c1_r, c2_r, c3_r;
  logic signed [32:0] d_r;
  logic        [61:0] tt_r;
  logic signed [64:0] m1_r, m2_r, m3_r, m4_r, m5_r;
  logic    [QW-1:0]   t3_r, den_r, rem_r, q_r;
  logic signed [QW-1:0] att_r, num_r, num_b_r;
  logic               neg_r, tgt_c3_r;
  logic [CNT_W-1:0]   cnt_r;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  logic signed [QW-1:0] dw;
  logic    [QW-1:0]   rem_sh;
  logic      [QW:0]   diff;
  logic      [63:0]   q_lim;
  logic               q_over;
  coef_t              div_res;

  assign start = cfg_wr_en && (cfg_index <= REG_BOUNDARY_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pos_r <= '0;
      start_vel_r <= '0;
      start_acc_r <= '0;
      end_pos_r   <= '0;
      horizon_r   <= '0;
      mode_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_POSITION:     start_pos_r <= cfg_wr_data;
        REG_START_VELOCITY:     start_vel_r <= cfg_wr_data;
        REG_START_ACCELERATION: start_acc_r <= cfg_wr_data;
        REG_END_POSITION:       end_pos_r   <= cfg_wr_data;
        REG_HORIZON:            horizon_r   <= cfg_wr_data[30:0];
        REG_BOUNDARY_MODE:      mode_r      <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operands per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL0: begin mul_a = {2'b0, horizon_r};     mul_b = {1'b0, horizon_r}; end
      ST_MUL1: begin mul_a = {2'b0, tt_r[61:31]};   mul_b = {1'b0, horizon_r}; end
      ST_MUL2: begin mul_a = {2'b0, tt_r[30:0]};    mul_b = {1'b0, horizon_r}; end
      ST_MUL3: begin mul_a = {start_vel_r, 1'b0};   mul_b = {1'b0, horizon_r}; end
      ST_MUL4: begin
        if (mode_r) begin
          mul_a = {start_vel_r[31], start_vel_r};
          mul_b = {1'b0, horizon_r};
        end else begin
          mul_a = {start_acc_r[31], start_acc_r};
          mul_b = {1'b0, tt_r[61:31]};
        end
      end
      ST_MUL5: begin mul_a = {start_acc_r[31], start_acc_r}; mul_b = {1'b0, tt_r[30:0]}; end
      default: ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign dw     = {{(QW-33){d_r[32]}}, d_r};
  assign rem_sh = {rem_r[QW-2:0], num_r[QW-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, den_r};
  assign q_lim  = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign q_over = (|q_r[QW-1:64]) || (q_r[63:0] > q_lim);

  always_comb begin
    if (q_over)
      div_res = neg_r ? coef_t'(64'h8000_0000_0000_0000) : coef_t'(64'h7FFF_FFFF_FFFF_FFFF);
    else if (neg_r)
      div_res = coef_t'(64'd0 - q_r[63:0]);
    else
      div_res = coef_t'(q_r[63:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      c0_r    <= '0;
      c1_r    <= '0;
      c2_r    <= '0;
      c3_r    <= '0;
    end else if (start) begin
      state_r <= ST_INIT;
    end else begin
      unique case (state_r)
        ST_IDLE: ;
        ST_INIT: begin
          if (horizon_r == '0) begin
            valid_r <= 1'b0;
            c0_r    <= '0;
            c1_r    <= '0;
            c2_r    <= '0;
            c3_r    <= '0;
            state_r <= ST_IDLE;
          end else begin
            valid_r <= 1'b1;
            c0_r    <= coef_t'({{32{start_pos_r[31]}}, start_pos_r}) <<< UP;
            c1_r    <= coef_t'({{32{start_vel_r[31]}}, start_vel_r}) <<< UP;
            if (!mode_r)
              c2_r  <= coef_t'({{32{start_acc_r[31]}}, start_acc_r}) <<< (UP - 1);
            d_r     <= {end_pos_r[31], end_pos_r} - {start_pos_r[31], start_pos_r};
            state_r <= ST_MUL0;
          end
        end
        ST_MUL0: begin tt_r <= prod[61:0]; state_r <= ST_MUL1; end
        ST_MUL1: begin m1_r <= prod;       state_r <= ST_MUL2; end
        ST_MUL2: begin m2_r <= prod;       state_r <= ST_MUL3; end
        ST_MUL3: begin m3_r <= prod;       state_r <= ST_MUL4; end
        ST_MUL4: begin m4_r <= prod;       state_r <= ST_MUL5; end
        ST_MUL5: begin m5_r <= prod;       state_r <= ST_SUM;  end
        ST_SUM: begin
          t3_r    <= (ext_wide(m1_r) <<< 31) + ext_wide(m2_r);
          att_r   <= (ext_wide(m4_r) <<< 31) + ext_wide(m5_r);
          state_r <= ST_NUM;
        end
        ST_NUM: begin
          if (!mode_r) begin
            num_r    <= ((dw <<< (2*FRACTION_BITS + 1)) - (ext_wide(m3_r) <<< FRACTION_BITS)
                         - att_r) <<< (COEF_FRAC - 1);
            den_r    <= t3_r;
            tgt_c3_r <= 1'b1;
          end else begin
            num_r    <= ((dw <<< FRACTION_BITS) + (dw <<< (FRACTION_BITS + 1))
                         - ext_wide(m3_r)) <<< COEF_FRAC;
            den_r    <= {{(QW-62){1'b0}}, tt_r};
            num_b_r  <= (ext_wide(m4_r) - (dw <<< (FRACTION_BITS + 1)))
                         <<< (FRACTION_BITS + COEF_FRAC);
            tgt_c3_r <= 1'b0;
          end
          state_r <= ST_DNEG;
        end
        ST_DNEG: begin
          neg_r <= num_r[QW-1];
          if (num_r[QW-1])
            num_r <= -num_r;
          state_r <= ST_DADD;
        end
        ST_DADD: begin
          // bias by half the divisor for round to nearest
          num_r   <= num_r + $signed({1'b0, den_r[QW-1:1]});
          rem_r   <= '0;
          q_r     <= '0;
          cnt_r   <= CNT_W'(QW - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          num_r <= num_r <<< 1;
          if (!diff[QW]) begin
            rem_r <= diff[QW-1:0];
            q_r   <= {q_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[QW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0)
            state_r <= ST_DEND;
        end
        ST_DEND: begin
          if (tgt_c3_r) begin
            c3_r    <= div_res;
            state_r <= ST_IDLE;
          end else begin
            c2_r     <= div_res;
            num_r    <= num_b_r;
            den_r    <= t3_r;
            tgt_c3_r <= 1'b1;
            state_r  <= ST_DNEG;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign solve_o.busy         = (state_r != ST_IDLE);
  assign solve_o.solved_valid = valid_r;
  assign solve_o.c0           = c0_r;
  assign solve_o.c1           = c1_r;
  assign solve_o.c2           = c2_r;
  assign solve_o.c3           = c3_r;

endmodule
